// ===== sv/rsi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

	// Direction and normal components carry this many fraction bits.
	localparam int DIR_FRAC = 30;
	localparam logic signed [31:0] UNIT_Q30 = 32'sh4000_0000;

	// Operand widths, each just wide enough for its worst case.
	localparam int NUM_W  = 67;  // plane n.(x-p0)
	localparam int DEN_W  = 66;  // plane n.v
	localparam int H_W    = 67;  // sphere v.(x-c)
	localparam int A_W    = 62;  // sphere v.v
	localparam int RAD_W  = 127; // non-negative discriminant
	localparam int ROOT_W = 64;  // its integer square root
	localparam int MAG_W  = 68;  // distance numerator before scaling
	localparam int DVS_W  = 62;  // distance divisor
	localparam int QUO_W  = 32;  // distance width

	typedef enum logic [2:0] {
		REG_KIND   = 3'd0,
		REG_ORG_X  = 3'd1,
		REG_ORG_Y  = 3'd2,
		REG_ORG_Z  = 3'd3,
		REG_NRM_X  = 3'd4,
		REG_NRM_Y  = 3'd5,
		REG_NRM_Z  = 3'd6,
		REG_RADIUS = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] org_x;
		logic signed [31:0] org_y;
		logic signed [31:0] org_z;
		logic signed [31:0] nrm_x;
		logic signed [31:0] nrm_y;
		logic signed [31:0] nrm_z;
		logic [30:0]        radius;
	} cfg_t;

	// Per-item values that ride alongside the square root.
	typedef struct packed {
		logic                    kind;
		logic                    sense;
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
		logic signed [H_W-1:0]   h;
		logic [A_W-1:0]          a;
		logic                    sph_ok;
	} side_t;

	function automatic logic signed [31:0] clamp_unit(input logic signed [31:0] x);
		logic signed [31:0] r;
		r = x;
		if (x > UNIT_Q30) r = UNIT_Q30;
		if (x < -UNIT_Q30) r = -UNIT_Q30;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/rsi_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsi_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_vld,
	input  rsi_pkg::cfg_t                 cfg,
	input  logic signed [31:0]            pos_x,
	input  logic signed [31:0]            pos_y,
	input  logic signed [31:0]            pos_z,
	input  logic signed [31:0]            dir_x,
	input  logic signed [31:0]            dir_y,
	input  logic signed [31:0]            dir_z,
	output logic                          out_vld,
	output rsi_pkg::side_t                out_side,
	output logic [rsi_pkg::RAD_W-1:0]     out_rad
);

	logic signed [31:0] pos_a [3];
	logic signed [31:0] dir_a [3];
	logic signed [31:0] org_a [3];
	logic signed [31:0] nrm_a [3];

	assign pos_a[0] = pos_x;
	assign pos_a[1] = pos_y;
	assign pos_a[2] = pos_z;
	assign dir_a[0] = dir_x;
	assign dir_a[1] = dir_y;
	assign dir_a[2] = dir_z;
	assign org_a[0] = cfg.org_x;
	assign org_a[1] = cfg.org_y;
	assign org_a[2] = cfg.org_z;
	assign nrm_a[0] = cfg.nrm_x;
	assign nrm_a[1] = cfg.nrm_y;
	assign nrm_a[2] = cfg.nrm_z;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Stage 1: offsets from the origin and clamped unit vectors.
	logic               kind_s1;
	logic [30:0]        rad_s1;
	logic signed [32:0] d_s1 [3];
	logic signed [31:0] v_s1 [3];
	logic signed [31:0] n_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= cfg.kind;
			rad_s1  <= cfg.radius;
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= 33'(pos_a[i]) - 33'(org_a[i]);
				v_s1[i] <= rsi_pkg::clamp_unit(dir_a[i]);
				n_s1[i] <= rsi_pkg::clamp_unit(nrm_a[i]);
			end
		end
	end

	// Stage 2: all first-level products.
	logic               kind_s2;
	logic signed [64:0] pnd_s2 [3];
	logic signed [63:0] pnv_s2 [3];
	logic signed [64:0] pvd_s2 [3];
	logic signed [65:0] pdd_s2 [3];
	logic [60:0]        pvv_s2 [3];
	logic signed [64:0] pxa_s2 [3];
	logic signed [64:0] pxb_s2 [3];
	logic [61:0]        rr_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			rr_s2   <= 62'(rad_s1) * 62'(rad_s1);
			for (int i = 0; i < 3; i++) begin
				pnd_s2[i] <= n_s1[i] * d_s1[i];
				pnv_s2[i] <= n_s1[i] * v_s1[i];
				pvd_s2[i] <= v_s1[i] * d_s1[i];
				pdd_s2[i] <= d_s1[i] * d_s1[i];
				pvv_s2[i] <= 61'(v_s1[i] * v_s1[i]);
			end
			// Cross product v x d, one pair of terms per component.
			pxa_s2[0] <= v_s1[1] * d_s1[2];
			pxb_s2[0] <= v_s1[2] * d_s1[1];
			pxa_s2[1] <= v_s1[2] * d_s1[0];
			pxb_s2[1] <= v_s1[0] * d_s1[2];
			pxa_s2[2] <= v_s1[0] * d_s1[1];
			pxb_s2[2] <= v_s1[1] * d_s1[0];
		end
	end

	// Stage 3: dot products, cross product magnitudes and the sense.
	logic signed [rsi_pkg::NUM_W-1:0] num_c;
	logic signed [rsi_pkg::DEN_W-1:0] den_c;
	logic signed [rsi_pkg::H_W-1:0]   h_c;
	logic [67:0]                      dd_c;
	logic [rsi_pkg::A_W-1:0]          a_c;
	logic signed [65:0]               cx_c [3];
	logic [62:0]                      cxm_c [3];

	always_comb begin
		num_c = rsi_pkg::NUM_W'(pnd_s2[0]) + rsi_pkg::NUM_W'(pnd_s2[1])
			+ rsi_pkg::NUM_W'(pnd_s2[2]);
		den_c = rsi_pkg::DEN_W'(pnv_s2[0]) + rsi_pkg::DEN_W'(pnv_s2[1])
			+ rsi_pkg::DEN_W'(pnv_s2[2]);
		h_c = rsi_pkg::H_W'(pvd_s2[0]) + rsi_pkg::H_W'(pvd_s2[1])
			+ rsi_pkg::H_W'(pvd_s2[2]);
		dd_c = 68'(pdd_s2[0]) + 68'(pdd_s2[1]) + 68'(pdd_s2[2]);
		a_c = rsi_pkg::A_W'(pvv_s2[0]) + rsi_pkg::A_W'(pvv_s2[1])
			+ rsi_pkg::A_W'(pvv_s2[2]);
		for (int i = 0; i < 3; i++) begin
			cx_c[i]  = 66'(pxa_s2[i]) - 66'(pxb_s2[i]);
			cxm_c[i] = cx_c[i][65] ? 63'(-cx_c[i]) : 63'(cx_c[i]);
		end
	end

	rsi_pkg::side_t side_s3;
	logic [62:0]    cxm_s3 [3];
	logic [61:0]    rr_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3.kind   <= kind_s2;
			side_s3.sense  <= kind_s2 ? (dd_c > 68'(rr_s2)) : (num_c > 0);
			side_s3.num    <= num_c;
			side_s3.den    <= den_c;
			side_s3.h      <= h_c;
			side_s3.a      <= a_c;
			side_s3.sph_ok <= 1'b0;
			rr_s3          <= rr_s2;
			for (int i = 0; i < 3; i++) cxm_s3[i] <= cxm_c[i];
		end
	end

	// Stage 4: wide squares and a*r^2 split into 32-bit partial products.
	rsi_pkg::side_t side_s4;
	logic [63:0]    cll_s4 [3];
	logic [62:0]    clh_s4 [3];
	logic [62:0]    chl_s4 [3];
	logic [61:0]    chh_s4 [3];
	logic [63:0]    all_s4;
	logic [61:0]    alh_s4;
	logic [61:0]    ahl_s4;
	logic [59:0]    ahh_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_s3;
			for (int i = 0; i < 3; i++) begin
				cll_s4[i] <= 64'(cxm_s3[i][31:0]) * 64'(cxm_s3[i][31:0]);
				clh_s4[i] <= 63'(cxm_s3[i][31:0]) * 63'(cxm_s3[i][62:32]);
				chl_s4[i] <= 63'(cxm_s3[i][62:32]) * 63'(cxm_s3[i][31:0]);
				chh_s4[i] <= 62'(cxm_s3[i][62:32]) * 62'(cxm_s3[i][62:32]);
			end
			all_s4 <= 64'(side_s3.a[31:0]) * 64'(rr_s3[31:0]);
			alh_s4 <= 62'(side_s3.a[31:0]) * 62'(rr_s3[61:32]);
			ahl_s4 <= 62'(side_s3.a[61:32]) * 62'(rr_s3[31:0]);
			ahh_s4 <= 60'(side_s3.a[61:32]) * 60'(rr_s3[61:32]);
		end
	end

	// Stage 5: partial products recombined.
	rsi_pkg::side_t side_s5;
	logic [125:0]   sq_s5 [3];
	logic [123:0]   arr_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= (126'(chh_s4[i]) << 64) + (126'(clh_s4[i]) << 32)
					+ (126'(chl_s4[i]) << 32) + 126'(cll_s4[i]);
			end
			arr_s5 <= (124'(ahh_s4) << 64) + (124'(alh_s4) << 32)
				+ (124'(ahl_s4) << 32) + 124'(all_s4);
		end
	end

	// Stage 6: discriminant a*r^2 - |v x d|^2, kept modulo 2^128.
	logic [127:0] disc_c;

	assign disc_c = 128'(arr_s5) - 128'(sq_s5[0]) - 128'(sq_s5[1]) - 128'(sq_s5[2]);

	rsi_pkg::side_t side_c;

	always_comb begin
		side_c        = side_s5;
		side_c.sph_ok = (side_s5.a != '0) && !disc_c[127];
	end

	rsi_pkg::side_t               side_s6;
	logic [rsi_pkg::RAD_W-1:0]    rad_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s6 <= side_c;
			rad_s6  <= disc_c[rsi_pkg::RAD_W-1:0];
		end
	end

	assign out_vld  = vld_s6;
	assign out_side = side_s6;
	assign out_rad  = rad_s6;

	a_clamp_x: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (v_s1[0] <= rsi_pkg::UNIT_Q30) && (v_s1[0] >= -rsi_pkg::UNIT_Q30))
		else $error("direction x left the unit range after clamping");
	a_clamp_n: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (n_s1[2] <= rsi_pkg::UNIT_Q30) && (n_s1[2] >= -rsi_pkg::UNIT_Q30))
		else $error("normal z left the unit range after clamping");

endmodule

`default_nettype wire

// ===== sv/rsi_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Integer square root, one result bit per stage.
module rsi_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_vld,
	input  logic [rsi_pkg::RAD_W-1:0]     in_rad,
	input  rsi_pkg::side_t                in_side,
	output logic                          out_vld,
	output logic [rsi_pkg::ROOT_W-1:0]    out_root,
	output rsi_pkg::side_t                out_side
);

	localparam int NST = rsi_pkg::ROOT_W;
	localparam int RW  = rsi_pkg::RAD_W;
	localparam int TW  = RW + 2;

	logic                          vld_sn  [NST];
	logic [RW-1:0]                 rem_sn  [NST];
	logic [rsi_pkg::ROOT_W-1:0]    root_sn [NST];
	rsi_pkg::side_t                side_sn [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		localparam int B = NST - 1 - k;

		logic                       vld_pv;
		logic [RW-1:0]              rem_pv;
		logic [rsi_pkg::ROOT_W-1:0] root_pv;
		rsi_pkg::side_t             side_pv;
		logic [TW-1:0]              trial;
		logic                       ge;

		if (k == 0) begin : g_first
			assign vld_pv  = in_vld;
			assign rem_pv  = in_rad;
			assign root_pv = '0;
			assign side_pv = in_side;
		end else begin : g_next
			assign vld_pv  = vld_sn[k-1];
			assign rem_pv  = rem_sn[k-1];
			assign root_pv = root_sn[k-1];
			assign side_pv = side_sn[k-1];
		end

		// (r + 2^B)^2 - r^2; the root has no bits at or below B yet, so OR adds.
		assign trial = (TW'(root_pv) << (B + 1)) | (TW'(1) << (2 * B));
		assign ge    = TW'(rem_pv) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k] <= 1'b0;
			end else if (adv) begin
				vld_sn[k] <= vld_pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sn[k]  <= ge ? (rem_pv - trial[RW-1:0]) : rem_pv;
				root_sn[k] <= root_pv | (rsi_pkg::ROOT_W'(ge) << B);
				side_sn[k] <= side_pv;
			end
		end
	end

	assign out_vld  = vld_sn[NST-1];
	assign out_root = root_sn[NST-1];
	assign out_side = side_sn[NST-1];

	// What is left of the radicand never reaches the gap to the next square.
	a_root_tight: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sn[NST-1] |-> TW'(rem_sn[NST-1]) <= (TW'(root_sn[NST-1]) << 1))
		else $error("square root remainder too large");

endmodule

`default_nettype wire

// ===== sv/rsi_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Picks the distance numerator and divisor, then divides one quotient bit per stage.
module rsi_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_vld,
	input  logic [rsi_pkg::ROOT_W-1:0]    in_root,
	input  rsi_pkg::side_t                in_side,
	output logic                          out_vld,
	output logic                          out_sense,
	output logic                          out_hit,
	output logic [rsi_pkg::QUO_W-1:0]     out_dist
);

	localparam int NST = rsi_pkg::QUO_W;
	localparam int NW  = rsi_pkg::MAG_W + rsi_pkg::DIR_FRAC;
	localparam int DW  = rsi_pkg::DVS_W;

	typedef struct packed {
		logic          hit;
		logic          sense;
		logic          sat;
		logic [DW-1:0] dvs;
	} dv_side_t;

	// Stage 1: roots of the sphere, sign tests of the plane.
	logic signed [68:0]               nh_c;
	logic signed [68:0]               rt_c;
	logic signed [68:0]               n1_c;
	logic signed [68:0]               n2_c;
	logic                             phit_c;
	logic [rsi_pkg::MAG_W-1:0]        pmag_c;
	logic [rsi_pkg::DEN_W-1:0]        pden_c;

	always_comb begin
		nh_c   = -69'(in_side.h);
		rt_c   = $signed({5'b0, in_root});
		n1_c   = nh_c - rt_c;
		n2_c   = nh_c + rt_c;
		phit_c = (in_side.den != '0) && ((in_side.num == '0)
			|| (in_side.num[rsi_pkg::NUM_W-1] != in_side.den[rsi_pkg::DEN_W-1]));
		pmag_c = in_side.num[rsi_pkg::NUM_W-1] ? rsi_pkg::MAG_W'(-in_side.num)
			: rsi_pkg::MAG_W'(in_side.num);
		pden_c = in_side.den[rsi_pkg::DEN_W-1] ? rsi_pkg::DEN_W'(-in_side.den)
			: rsi_pkg::DEN_W'(in_side.den);
	end

	logic                      vld_s1, vld_s2;
	logic                      hit_s1, sense_s1;
	logic [rsi_pkg::MAG_W-1:0] mag_s1;
	logic [DW-1:0]             dvs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sense_s1 <= in_side.sense;
			if (!in_side.kind) begin
				hit_s1 <= phit_c;
				mag_s1 <= pmag_c;
				dvs_s1 <= pden_c[DW-1:0];
			end else begin
				hit_s1 <= in_side.sph_ok && ((n1_c > 0) || (n2_c > 0));
				mag_s1 <= (n1_c > 0) ? n1_c[rsi_pkg::MAG_W-1:0] : n2_c[rsi_pkg::MAG_W-1:0];
				dvs_s1 <= in_side.a;
			end
		end
	end

	// Stage 2: scale the numerator and test for an overflowing quotient.
	logic [NW-1:0] numer_c;
	logic [NW-1:0] rem_s2;
	dv_side_t      side_s2;

	assign numer_c = NW'(mag_s1) << rsi_pkg::DIR_FRAC;

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s2        <= numer_c;
			side_s2.hit   <= hit_s1;
			side_s2.sense <= sense_s1;
			side_s2.sat   <= numer_c >= (NW'(dvs_s1) << NST);
			side_s2.dvs   <= dvs_s1;
		end
	end

	logic             vld_sn  [NST];
	logic [NW-1:0]    rem_sn  [NST];
	logic [NST-1:0]   quo_sn  [NST];
	dv_side_t         side_sn [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		localparam int B = NST - 1 - k;

		logic           vld_pv;
		logic [NW-1:0]  rem_pv;
		logic [NST-1:0] quo_pv;
		dv_side_t       side_pv;
		logic [NW-1:0]  sub;
		logic           ge;

		if (k == 0) begin : g_first
			assign vld_pv  = vld_s2;
			assign rem_pv  = rem_s2;
			assign quo_pv  = '0;
			assign side_pv = side_s2;
		end else begin : g_next
			assign vld_pv  = vld_sn[k-1];
			assign rem_pv  = rem_sn[k-1];
			assign quo_pv  = quo_sn[k-1];
			assign side_pv = side_sn[k-1];
		end

		assign sub = NW'(side_pv.dvs) << B;
		assign ge  = rem_pv >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k] <= 1'b0;
			end else if (adv) begin
				vld_sn[k] <= vld_pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sn[k]  <= ge ? (rem_pv - sub) : rem_pv;
				quo_sn[k]  <= quo_pv | (NST'(ge) << B);
				side_sn[k] <= side_pv;
			end
		end
	end

	assign out_vld   = vld_sn[NST-1];
	assign out_sense = side_sn[NST-1].sense;
	assign out_hit   = side_sn[NST-1].hit;
	assign out_dist  = !side_sn[NST-1].hit ? '0
		: (side_sn[NST-1].sat ? '1 : quo_sn[NST-1]);

	a_rem_small: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sn[NST-1] && side_sn[NST-1].hit && !side_sn[NST-1].sat
		|-> rem_sn[NST-1] < NW'(side_sn[NST-1].dvs))
		else $error("division remainder not below divisor");
	a_hit_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && side_s2.hit |-> side_s2.dvs != '0)
		else $error("hit with a zero divisor");

endmodule

`default_nettype wire

// ===== sv/ray_surface_intersection.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ray against one configured surface (plane or sphere).
// Input channel: in_valid/in_stall with pos_x/y/z (signed Q16.16) and
// dir_x/y/z (signed Q1.30). A transfer happens on a clock edge with in_valid
// high and in_stall low. Output channel: out_valid/out_stall with sense, hit
// and distance (unsigned Q16.16, saturated, 0 on a miss); one result per input.
// Throughput is one item per cycle. An input transfer reaches out_valid through
// 6 product stages, 64 square root stages (one root bit each), 34 divider
// stages (two setup stages, then one quotient bit each) and the output
// register. The whole pipeline advances together; while out_valid is
// high and out_stall is asserted nothing moves and in_stall is raised, so no
// result is lost or repeated. Surface registers are written through
// cfg_wr_en/cfg_index/cfg_data and must only change while no item is in flight.
// Reset empties the pipeline and sets a plane through the origin with normal
// +z and a zero sphere radius.
module ray_surface_intersection (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               sense,
	output logic               hit,
	output logic [31:0]        distance
);

	rsi_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind   <= 1'b0;
			cfg_q.org_x  <= '0;
			cfg_q.org_y  <= '0;
			cfg_q.org_z  <= '0;
			cfg_q.nrm_x  <= '0;
			cfg_q.nrm_y  <= '0;
			cfg_q.nrm_z  <= rsi_pkg::UNIT_Q30;
			cfg_q.radius <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rsi_pkg::REG_KIND:   cfg_q.kind   <= cfg_data[0];
				rsi_pkg::REG_ORG_X:  cfg_q.org_x  <= cfg_data;
				rsi_pkg::REG_ORG_Y:  cfg_q.org_y  <= cfg_data;
				rsi_pkg::REG_ORG_Z:  cfg_q.org_z  <= cfg_data;
				rsi_pkg::REG_NRM_X:  cfg_q.nrm_x  <= cfg_data;
				rsi_pkg::REG_NRM_Y:  cfg_q.nrm_y  <= cfg_data;
				rsi_pkg::REG_NRM_Z:  cfg_q.nrm_z  <= cfg_data;
				rsi_pkg::REG_RADIUS: cfg_q.radius <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic out_valid_q;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	logic                             fr_vld;
	rsi_pkg::side_t                   fr_side;
	logic [rsi_pkg::RAD_W-1:0]        fr_rad;
	logic                             sq_vld;
	logic [rsi_pkg::ROOT_W-1:0]       sq_root;
	rsi_pkg::side_t                   sq_side;
	logic                             dv_vld;
	logic                             dv_sense;
	logic                             dv_hit;
	logic [rsi_pkg::QUO_W-1:0]        dv_dist;

	rsi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (in_valid),
		.cfg      (cfg_q),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.dir_z    (dir_z),
		.out_vld  (fr_vld),
		.out_side (fr_side),
		.out_rad  (fr_rad)
	);

	rsi_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (fr_vld),
		.in_rad   (fr_rad),
		.in_side  (fr_side),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	rsi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_vld    (sq_vld),
		.in_root   (sq_root),
		.in_side   (sq_side),
		.out_vld   (dv_vld),
		.out_sense (dv_sense),
		.out_hit   (dv_hit),
		.out_dist  (dv_dist)
	);

	logic        sense_q;
	logic        hit_q;
	logic [31:0] dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sense_q <= dv_sense;
			hit_q   <= dv_hit;
			dist_q  <= dv_dist;
		end
	end

	assign out_valid = out_valid_q;
	assign sense     = sense_q;
	assign hit       = hit_q;
	assign distance  = dist_q;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> distance == '0)
		else $error("miss reported with a nonzero distance");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(dist_q) && $stable(hit_q))
		else $error("held result changed while the receiver stalled");

endmodule

`default_nettype wire
